>>> rtl/mclm_pkg.sv
// ============================================================================
// mclm_pkg
// Shared types and codes for the mutex and condition lock manager.
// ============================================================================
package mclm_pkg;

    localparam int ID_W      = 31;
    localparam int PROC_W    = 16;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] stat_t;

    // Operation codes.
    localparam func_t FN_LOCK   = 3'd0;
    localparam func_t FN_UNLOCK = 3'd1;
    localparam func_t FN_WAIT   = 3'd2;
    localparam func_t FN_BCAST  = 3'd3;
    localparam func_t FN_CLEAN  = 3'd4;

    // Final status codes.
    localparam stat_t ST_OK     = 2'd0;
    localparam stat_t ST_QUEUED = 2'd1;
    localparam stat_t ST_NONE   = 2'd2;
    localparam stat_t ST_FULL   = 2'd3;

    // Operation applied to every cell of the wait queue in the same cycle.
    typedef struct packed {
        logic wr;
        logic drop;
    } wq_op_t;

endpackage

>>> rtl/mclm_wait_cell.sv
// ============================================================================
// mclm_wait_cell
// One entry of the FIFO wait queue. On a drop, every cell at or above the
// dropped position takes its right neighbor's entry; on a write, the cell at
// the fill position takes the new entry.
// ============================================================================
module mclm_wait_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6,
    parameter int PW  = 16
) (
    input  logic                       aclk,
    input  mclm_pkg::wq_op_t           op,
    input  logic [CW-1:0]              wr_pos,
    input  logic [CW-1:0]              drop_pos,
    input  logic [mclm_pkg::ID_W-1:0]  new_mutex,
    input  logic [PW-1:0]              new_proc,
    input  logic [mclm_pkg::ID_W-1:0]  right_mutex,
    input  logic [PW-1:0]              right_proc,
    output logic [mclm_pkg::ID_W-1:0]  mutex,
    output logic [PW-1:0]              proc
);

    logic [mclm_pkg::ID_W-1:0] mutex_reg, mutex_next;
    logic [PW-1:0]             proc_reg, proc_next;

    // Select shift, load or hold for this entry.
    always_comb begin
        mutex_next = mutex_reg;
        proc_next  = proc_reg;
        if (op.drop && (CW'(IDX) >= drop_pos)) begin
            mutex_next = right_mutex;
            proc_next  = right_proc;
        end else if (op.wr && (CW'(IDX) == wr_pos)) begin
            mutex_next = new_mutex;
            proc_next  = new_proc;
        end
    end

    always_ff @(posedge aclk) begin
        mutex_reg <= mutex_next;
        proc_reg  <= proc_next;
    end

    assign mutex = mutex_reg;
    assign proc  = proc_reg;

endmodule

>>> rtl/mutex_condvar_lock_manager.sv
// Lock and unlock scan the lock table and wait queue, and wait needs no scan; broadcast
// walks the sleeper list, and cleanup walks the wait queue and lock table, entry by entry.
// One transaction is processed at a time; results leave through one output register.
// Reset (aresetn low, synchronous) empties the lock table, wait queue and sleeper list.
// ============================================================================
// mutex_condvar_lock_manager
// Lock table, FIFO wait queue built as a chain of cells, and condition
// sleeper list, driven by a scanning sequencer.
// ============================================================================
module mutex_condvar_lock_manager #(
    parameter int LOCK_SLOTS  = 32,
    parameter int WAIT_SLOTS  = 32,
    parameter int SLEEP_SLOTS = 32,
    parameter int PROC_BITS   = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mutex_id[30:0], cond_id[61:31], proc_id[77:62], zero fill
    input  logic [mclm_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[2:0]
    input  logic [mclm_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // woken_proc[15:0], status[17:16], zero fill
    output logic [mclm_pkg::M_TDATA_W-1:0]     m_tdata,
    // wake[0]
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int LW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int SW = (SLEEP_SLOTS > 1) ? $clog2(SLEEP_SLOTS) : 1;
    localparam int IW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
    localparam int CW = $clog2(WAIT_SLOTS + 1);
    localparam int PW = (PROC_BITS < mclm_pkg::PROC_W) ? PROC_BITS : mclm_pkg::PROC_W;
    localparam int IDW = mclm_pkg::ID_W;

    typedef enum logic [3:0] {
        S_IDLE, S_HSCAN, S_DQSCAN, S_BSCAN, S_BNEXT, S_CWQ,
        S_CSLP, S_CHELD, S_CNEXT, S_EMIT, S_FINAL
    } state_t;

    // Control and payload registers.
    state_t                  state_reg, state_next, ret_reg, ret_next;
    mclm_pkg::func_t         func_reg, func_next;
    logic [IDW-1:0]          key_reg, key_next, cond_reg, cond_next;
    logic [PW-1:0]           proc_reg, proc_next, who_reg, who_next;
    logic [PW-1:0]           wk_reg, wk_next;
    logic [CW-1:0]           i_reg, i_next, count_reg, count_next;
    logic [LW-1:0]           j_reg, j_next;
    logic [SW-1:0]           k_reg, k_next;
    logic                    any_reg, any_next, full_reg, full_next;
    mclm_pkg::stat_t         stat_reg, stat_next;

    // Output register.
    logic                    m_valid_reg;
    logic                    m_wake_reg, m_last_reg;
    logic [PW-1:0]           m_proc_reg;
    mclm_pkg::stat_t         m_stat_reg;
    logic                    out_load, out_wake, out_last;
    logic [PW-1:0]           out_proc;
    mclm_pkg::stat_t         out_stat;

    // Lock table and sleeper list.
    logic [IDW-1:0]          held_ids_reg    [LOCK_SLOTS];
    logic [PW-1:0]           held_owners_reg [LOCK_SLOTS];
    logic [LOCK_SLOTS-1:0]   held_valid_reg;
    logic [IDW-1:0]          slp_conds_reg   [SLEEP_SLOTS];
    logic [IDW-1:0]          slp_mutexes_reg [SLEEP_SLOTS];
    logic [PW-1:0]           slp_procs_reg   [SLEEP_SLOTS];
    logic [SLEEP_SLOTS-1:0]  slp_valid_reg;

    // Table write strobes.
    logic                    hw_en, hw_valid, hw_use_free;
    logic [PW-1:0]           hw_owner;
    logic [LW-1:0]           hw_idx;
    logic                    sw_en, sclr_k, sclr_proc;

    // Wait queue cells.
    mclm_pkg::wq_op_t        wq_op;
    logic [IDW-1:0]          cw_mutex [WAIT_SLOTS];
    logic [PW-1:0]           cw_proc  [WAIT_SLOTS];

    // Decoded input fields.
    logic [IDW-1:0]          in_mutex, in_cond;
    logic [PW-1:0]           in_proc;
    assign in_mutex = s_tdata[30:0];
    assign in_cond  = s_tdata[61:31];
    assign in_proc  = s_tdata[62 +: PW];

    // Lowest free entries.
    logic                    free_h_found, free_s_found;
    logic [LW-1:0]           free_h_idx;
    logic [SW-1:0]           free_s_idx;
    always_comb begin
        free_h_found = 1'b0;
        free_h_idx   = '0;
        for (int n = LOCK_SLOTS - 1; n >= 0; n--) begin
            if (!held_valid_reg[n]) begin
                free_h_found = 1'b1;
                free_h_idx   = LW'(n);
            end
        end
        free_s_found = 1'b0;
        free_s_idx   = '0;
        for (int n = SLEEP_SLOTS - 1; n >= 0; n--) begin
            if (!slp_valid_reg[n]) begin
                free_s_found = 1'b1;
                free_s_idx   = SW'(n);
            end
        end
    end

    // Sleepers owned by the process under cleanup.
    logic [SLEEP_SLOTS-1:0]  slp_proc_hit;
    always_comb begin
        for (int n = 0; n < SLEEP_SLOTS; n++) begin
            slp_proc_hit[n] = slp_valid_reg[n] && (slp_procs_reg[n] == proc_reg);
        end
    end

    // Entries under the scan pointers.
    logic                    wq_in_range, wq_room, out_free;
    logic [IDW-1:0]          wq_m_i;
    logic [PW-1:0]           wq_p_i;
    logic                    h_id_hit, h_own_hit, s_hit;
    assign wq_in_range = i_reg < count_reg;
    assign wq_room     = count_reg != CW'(WAIT_SLOTS);
    assign wq_m_i      = cw_mutex[i_reg[IW-1:0]];
    assign wq_p_i      = cw_proc[i_reg[IW-1:0]];
    assign h_id_hit    = held_valid_reg[j_reg] && (held_ids_reg[j_reg] == key_reg);
    assign h_own_hit   = held_valid_reg[j_reg] && (held_owners_reg[j_reg] == proc_reg);
    assign s_hit       = slp_valid_reg[k_reg] && (slp_conds_reg[k_reg] == cond_reg);
    assign out_free    = !m_valid_reg || m_tready;

    // Sequencer.
    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        func_next   = func_reg;
        key_next    = key_reg;
        cond_next   = cond_reg;
        proc_next   = proc_reg;
        who_next    = who_reg;
        wk_next     = wk_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        any_next    = any_reg;
        full_next   = full_reg;
        stat_next   = stat_reg;
        count_next  = count_reg;
        hw_en       = 1'b0;
        hw_valid    = 1'b1;
        hw_use_free = 1'b0;
        hw_owner    = who_reg;
        sw_en       = 1'b0;
        sclr_k      = 1'b0;
        sclr_proc   = 1'b0;
        wq_op       = '0;
        out_load    = 1'b0;
        out_wake    = 1'b0;
        out_last    = 1'b0;
        out_proc    = wk_reg;
        out_stat    = mclm_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    func_next = s_tuser;
                    key_next  = in_mutex;
                    cond_next = in_cond;
                    proc_next = in_proc;
                    who_next  = in_proc;
                    i_next    = '0;
                    j_next    = '0;
                    k_next    = '0;
                    any_next  = 1'b0;
                    full_next = 1'b0;
                    unique case (s_tuser)
                        mclm_pkg::FN_LOCK, mclm_pkg::FN_UNLOCK: state_next = S_HSCAN;
                        mclm_pkg::FN_WAIT: begin
                            sw_en      = free_s_found;
                            stat_next  = free_s_found ? mclm_pkg::ST_OK : mclm_pkg::ST_FULL;
                            state_next = S_FINAL;
                        end
                        mclm_pkg::FN_BCAST: state_next = S_BSCAN;
                        mclm_pkg::FN_CLEAN: state_next = S_CWQ;
                        default: begin
                            stat_next  = mclm_pkg::ST_NONE;
                            state_next = S_FINAL;
                        end
                    endcase
                end
            end

            // Look for key_reg in the lock table, one entry a cycle.
            S_HSCAN: begin
                if (h_id_hit || (j_reg == LW'(LOCK_SLOTS - 1))) begin
                    if (func_reg == mclm_pkg::FN_UNLOCK) begin
                        if (h_id_hit) begin
                            i_next     = '0;
                            state_next = S_DQSCAN;
                        end else begin
                            stat_next  = mclm_pkg::ST_NONE;
                            state_next = S_FINAL;
                        end
                    end else if (h_id_hit) begin
                        // Taken mutex: queue the caller or sleeper.
                        wq_op.wr = wq_room;
                        if (wq_room) begin
                            count_next = count_reg + CW'(1);
                        end
                        if (func_reg == mclm_pkg::FN_LOCK) begin
                            stat_next  = wq_room ? mclm_pkg::ST_QUEUED : mclm_pkg::ST_FULL;
                            state_next = S_FINAL;
                        end else begin
                            sclr_k     = wq_room;
                            full_next  = full_reg || !wq_room;
                            state_next = S_BNEXT;
                        end
                    end else begin
                        // Free mutex: grant it in the lowest free entry.
                        hw_en       = free_h_found;
                        hw_use_free = 1'b1;
                        if (func_reg == mclm_pkg::FN_LOCK) begin
                            stat_next  = free_h_found ? mclm_pkg::ST_OK : mclm_pkg::ST_FULL;
                            state_next = S_FINAL;
                        end else if (free_h_found) begin
                            sclr_k     = 1'b1;
                            wk_next    = who_reg;
                            ret_next   = S_BNEXT;
                            state_next = S_EMIT;
                        end else begin
                            full_next  = 1'b1;
                            state_next = S_BNEXT;
                        end
                    end
                end else begin
                    j_next = j_reg + LW'(1);
                end
            end

            // Hand the entry at j_reg to its first waiter, or free it.
            S_DQSCAN: begin
                if (!wq_in_range) begin
                    hw_en    = 1'b1;
                    hw_valid = 1'b0;
                    if (func_reg == mclm_pkg::FN_UNLOCK) begin
                        stat_next  = mclm_pkg::ST_OK;
                        state_next = S_FINAL;
                    end else begin
                        state_next = S_CNEXT;
                    end
                end else if (wq_m_i == key_reg) begin
                    wq_op.drop = 1'b1;
                    count_next = count_reg - CW'(1);
                    hw_en      = 1'b1;
                    hw_owner   = wq_p_i;
                    wk_next    = wq_p_i;
                    stat_next  = mclm_pkg::ST_OK;
                    ret_next   = (func_reg == mclm_pkg::FN_UNLOCK) ? S_FINAL : S_CNEXT;
                    state_next = S_EMIT;
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end

            // Broadcast: visit each sleeper in slot order.
            S_BSCAN: begin
                if (s_hit) begin
                    any_next   = 1'b1;
                    key_next   = slp_mutexes_reg[k_reg];
                    who_next   = slp_procs_reg[k_reg];
                    j_next     = '0;
                    state_next = S_HSCAN;
                end else begin
                    state_next = S_BNEXT;
                end
            end

            S_BNEXT: begin
                if (k_reg == SW'(SLEEP_SLOTS - 1)) begin
                    stat_next  = full_reg ? mclm_pkg::ST_FULL
                               : (any_reg ? mclm_pkg::ST_OK : mclm_pkg::ST_NONE);
                    state_next = S_FINAL;
                end else begin
                    k_next     = k_reg + SW'(1);
                    state_next = S_BSCAN;
                end
            end

            // Cleanup: drop the process from the wait queue.
            S_CWQ: begin
                if (!wq_in_range) begin
                    state_next = S_CSLP;
                end else if (wq_p_i == proc_reg) begin
                    wq_op.drop = 1'b1;
                    count_next = count_reg - CW'(1);
                    any_next   = 1'b1;
                end else begin
                    i_next = i_reg + CW'(1);
                end
            end

            // Cleanup: remove its sleepers all at once.
            S_CSLP: begin
                sclr_proc  = 1'b1;
                any_next   = any_reg || (|slp_proc_hit);
                j_next     = '0;
                state_next = S_CHELD;
            end

            // Cleanup: release each mutex it owns.
            S_CHELD: begin
                if (h_own_hit) begin
                    any_next   = 1'b1;
                    key_next   = held_ids_reg[j_reg];
                    i_next     = '0;
                    state_next = S_DQSCAN;
                end else begin
                    state_next = S_CNEXT;
                end
            end

            S_CNEXT: begin
                if (j_reg == LW'(LOCK_SLOTS - 1)) begin
                    stat_next  = any_reg ? mclm_pkg::ST_OK : mclm_pkg::ST_NONE;
                    state_next = S_FINAL;
                end else begin
                    j_next     = j_reg + LW'(1);
                    state_next = S_CHELD;
                end
            end

            // Send a wake result.
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_wake   = 1'b1;
                    state_next = ret_reg;
                end
            end

            // Send the final result.
            S_FINAL: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    out_proc   = '0;
                    out_stat   = stat_reg;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign hw_idx = hw_use_free ? free_h_idx : j_reg;

    // Control state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            count_reg      <= '0;
            held_valid_reg <= '0;
            slp_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
            if (hw_en) begin
                held_valid_reg[hw_idx] <= hw_valid;
            end
            if (sw_en) begin
                slp_valid_reg[free_s_idx] <= 1'b1;
            end else if (sclr_k) begin
                slp_valid_reg[k_reg] <= 1'b0;
            end else if (sclr_proc) begin
                slp_valid_reg <= slp_valid_reg & ~slp_proc_hit;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_wake_reg  <= out_wake;
                m_last_reg  <= out_last;
                m_proc_reg  <= out_proc;
                m_stat_reg  <= out_stat;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        key_reg  <= key_next;
        cond_reg <= cond_next;
        proc_reg <= proc_next;
        who_reg  <= who_next;
        wk_reg   <= wk_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        any_reg  <= any_next;
        full_reg <= full_next;
        stat_reg <= stat_next;
        if (hw_en) begin
            held_ids_reg[hw_idx]    <= key_reg;
            held_owners_reg[hw_idx] <= hw_owner;
        end
        if (sw_en) begin
            slp_conds_reg[free_s_idx]   <= in_cond;
            slp_mutexes_reg[free_s_idx] <= in_mutex;
            slp_procs_reg[free_s_idx]   <= in_proc;
        end
    end

    // Wait queue as a chain of cells.
    for (genvar g = 0; g < WAIT_SLOTS; g++) begin : g_wq
        logic [IDW-1:0] right_m;
        logic [PW-1:0]  right_p;
        if (g == WAIT_SLOTS - 1) begin : g_end
            assign right_m = cw_mutex[g];
            assign right_p = cw_proc[g];
        end else begin : g_mid
            assign right_m = cw_mutex[g + 1];
            assign right_p = cw_proc[g + 1];
        end
        mclm_wait_cell #(
            .IDX (g),
            .CW  (CW),
            .PW  (PW)
        ) u_cell (
            .aclk        (aclk),
            .op          (wq_op),
            .wr_pos      (count_reg),
            .drop_pos    (i_reg),
            .new_mutex   (key_reg),
            .new_proc    (who_reg),
            .right_mutex (right_m),
            .right_proc  (right_p),
            .mutex       (cw_mutex[g]),
            .proc        (cw_proc[g])
        );
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_stat_reg, mclm_pkg::PROC_W'(m_proc_reg)};
    assign m_tuser  = m_wake_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/mclm_checker.sv
// ============================================================================
// mclm_checker
// Port-level checks for the lock manager, bound to the top level.
// ============================================================================
module mclm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // A wake result carries status zero and is never the final one.
    a_wake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata[17:16] == 2'd0))
        else $error("malformed wake result");

    // The final result names no process.
    a_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser && (m_tdata[15:0] == 16'd0))
        else $error("malformed final result");

    // One transaction at a time: input closes right after acceptance.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

endmodule

bind mutex_condvar_lock_manager mclm_checker u_mclm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
